>>> hw/rtl/vsmf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Value store mode finder package
// Shared constants, command codes and transaction payload types.
// ----------------------------------------------------------------------------
package vsmf_pkg;

   localparam int CAPACITY_DEF    = 64;
   localparam int VALUE_WIDTH_DEF = 32;

   localparam int CMD_W  = 2;
   localparam int DATA_W = 32;
   localparam int CNT_W  = 7;

   localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_COUNT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_MODE  = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]         command;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [CNT_W-1:0]         occurrences;
      logic signed [DATA_W-1:0] mode_value;
      logic                     empty_error;
      logic                     full_drop;
      logic [CNT_W-1:0]         entries;
   } rsp_type;

endpackage
`default_nettype wire

>>> hw/rtl/vsmf_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Value store memory
// One write port and two read ports; each read returns its data in the next cycle.
// ----------------------------------------------------------------------------
module vsmf_store #(
   parameter int CAPACITY    = vsmf_pkg::CAPACITY_DEF,
   parameter int VALUE_WIDTH = vsmf_pkg::VALUE_WIDTH_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [$clog2(CAPACITY)-1:0] wr_addr,
   input  wire logic [VALUE_WIDTH-1:0]      wr_data,
   input  wire logic [$clog2(CAPACITY)-1:0] rd_a_addr,
   output logic      [VALUE_WIDTH-1:0]      rd_a_data,
   input  wire logic [$clog2(CAPACITY)-1:0] rd_b_addr,
   output logic      [VALUE_WIDTH-1:0]      rd_b_data
);

   logic [VALUE_WIDTH-1:0] mem_ff [CAPACITY];
   logic [VALUE_WIDTH-1:0] rd_a_data_ff;
   logic [VALUE_WIDTH-1:0] rd_b_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_a_data_ff <= mem_ff[rd_a_addr];
      rd_b_data_ff <= mem_ff[rd_b_addr];
   end

   assign rd_a_data = rd_a_data_ff;
   assign rd_b_data = rd_b_data_ff;

endmodule
`default_nettype wire

>>> hw/rtl/vsmf_tally.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Tally scanner
// Walks the stored entries through one read port and counts matches of a key.
// ----------------------------------------------------------------------------
module vsmf_tally #(
   parameter int CAPACITY    = vsmf_pkg::CAPACITY_DEF,
   parameter int VALUE_WIDTH = vsmf_pkg::VALUE_WIDTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [$clog2(CAPACITY)-1:0]   last_idx,
   input  wire logic [VALUE_WIDTH-1:0]        key,
   input  wire logic [VALUE_WIDTH-1:0]        rd_data,
   output logic      [$clog2(CAPACITY)-1:0]   rd_addr,
   output logic      [$clog2(CAPACITY+1)-1:0] count,
   output logic                               done
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int TCNT_W = $clog2(CAPACITY + 1);

   logic              active_ff, active_in;
   logic [IDX_W-1:0]  addr_ff, addr_in;
   logic              pend_ff, pend_in;
   logic              last_ff, last_in;
   logic [TCNT_W-1:0] count_ff, count_in;
   logic              done_ff, done_in;

   // A read issued in one cycle returns its data in the next, so the compare
   // trails the address, and done is registered behind the last compare.
   always_comb begin
      active_in = active_ff;
      addr_in   = addr_ff;
      pend_in   = 1'b0;
      last_in   = 1'b0;
      count_in  = count_ff;
      done_in   = pend_ff && last_ff;
      if (start) begin
         active_in = 1'b1;
         addr_in   = '0;
         count_in  = '0;
      end else begin
         if (active_ff) begin
            pend_in = 1'b1;
            if (addr_ff == last_idx) begin
               active_in = 1'b0;
               last_in   = 1'b1;
            end else begin
               addr_in = addr_ff + IDX_W'(1);
            end
         end
         if (pend_ff && (rd_data == key)) begin
            count_in = count_ff + TCNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         addr_ff   <= '0;
         pend_ff   <= 1'b0;
         last_ff   <= 1'b0;
         count_ff  <= '0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         addr_ff   <= addr_in;
         pend_ff   <= pend_in;
         last_ff   <= last_in;
         count_ff  <= count_in;
         done_ff   <= done_in;
      end
   end

   assign rd_addr = addr_ff;
   assign count   = count_ff;
   assign done    = done_ff;

endmodule
`default_nettype wire

>>> hw/rtl/value_store_mode_finder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Value store mode finder
// Bounded store of signed values with add, count and mode commands.
// ----------------------------------------------------------------------------
// The block takes one transaction at a time and returns exactly one result
// transaction for each. A count or a mode runs longer as N, the number of
// stored values (up to CAPACITY), grows. That is set by the tally scanner,
// which reads one stored entry per cycle through the second read port of
// the store memory; a mode runs one such scan for every stored entry,
// fetched as the key through the first read port. An add, a mode or count
// on an empty store, and an unused command code go straight to the finish
// state with no scan. The result sits in an output register, so the next
// transaction is accepted while the previous result still waits to be
// taken.
// ----------------------------------------------------------------------------
module value_store_mode_finder #(
   parameter int CAPACITY    = vsmf_pkg::CAPACITY_DEF,
   parameter int VALUE_WIDTH = vsmf_pkg::VALUE_WIDTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire vsmf_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output vsmf_pkg::rsp_type      rsp_payload
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int FCNT_W = $clog2(CAPACITY + 1);

   // One-hot sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_KEY    = 4'b0010,
      ST_SCAN   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type                       state_ff, state_in;
   logic [FCNT_W-1:0]               fill_ff, fill_in;
   logic [vsmf_pkg::CMD_W-1:0]      cmd_ff, cmd_in;
   logic [VALUE_WIDTH-1:0]          key_ff, key_in;
   logic [IDX_W-1:0]                outer_ff, outer_in;
   logic [FCNT_W-1:0]               res_cnt_ff, res_cnt_in;
   logic [VALUE_WIDTH-1:0]          best_val_ff, best_val_in;
   logic                            empty_ff, empty_in;
   logic                            full_ff, full_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   vsmf_pkg::rsp_type               rsp_ff, rsp_in;

   logic                            req_accept;
   logic                            store_full;
   logic [FCNT_W-1:0]               fill_dec;
   logic [IDX_W-1:0]                last_idx;
   logic [63:0]                     value_wide;
   logic [63:0]                     best_wide;
   logic [VALUE_WIDTH-1:0]          value_in;

   logic                            mem_we;
   logic [VALUE_WIDTH-1:0]          key_data;
   logic [VALUE_WIDTH-1:0]          scan_data;
   logic [IDX_W-1:0]                scan_addr;
   logic                            tally_start;
   logic [VALUE_WIDTH-1:0]          tally_key;
   logic [FCNT_W-1:0]               tally_count;
   logic                            tally_done;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign store_full = (fill_ff == FCNT_W'(CAPACITY));

   // Only entries below the fill count are ever scanned.
   assign fill_dec = fill_ff - FCNT_W'(1);
   assign last_idx = fill_dec[IDX_W-1:0];

   // Incoming values are sign extended and then kept in VALUE_WIDTH bits.
   assign value_wide = {{32{req_payload.value[31]}}, req_payload.value};
   assign value_in   = value_wide[VALUE_WIDTH-1:0];

   // The mode value leaves as the low 32 bits of the stored pattern.
   assign best_wide = 64'(best_val_ff);

   // Writes happen only at the acceptance of an add, so no scan can see one.
   assign mem_we = req_accept && (req_payload.command == vsmf_pkg::CMD_ADD) && !store_full;

   // A count compares against the request value, a mode against the entry
   // held on the key read port.
   assign tally_key = (cmd_ff == vsmf_pkg::CMD_MODE) ? key_data : key_ff;

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      outer_in     = outer_ff;
      res_cnt_in   = res_cnt_ff;
      best_val_in  = best_val_ff;
      empty_in     = empty_ff;
      full_in      = full_ff;
      tally_start  = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cmd_in      = req_payload.command;
               key_in      = value_in;
               outer_in    = '0;
               res_cnt_in  = '0;
               best_val_in = '0;
               empty_in    = 1'b0;
               full_in     = 1'b0;
               state_in    = ST_FINISH;
               case (req_payload.command)
                  vsmf_pkg::CMD_ADD: begin
                     if (store_full) begin
                        full_in = 1'b1;
                     end else begin
                        fill_in = fill_ff + FCNT_W'(1);
                     end
                  end
                  vsmf_pkg::CMD_COUNT: begin
                     if (fill_ff != '0) begin
                        tally_start = 1'b1;
                        state_in    = ST_SCAN;
                     end
                  end
                  vsmf_pkg::CMD_MODE: begin
                     if (fill_ff == '0) begin
                        empty_in = 1'b1;
                     end else begin
                        state_in = ST_KEY;
                     end
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end

         ST_KEY: begin
            // The key read issued here lands before the first compare.
            tally_start = 1'b1;
            state_in    = ST_SCAN;
         end

         ST_SCAN: begin
            if (tally_done) begin
               if (cmd_ff == vsmf_pkg::CMD_MODE) begin
                  // Strictly greater keeps the earliest entry on a tie.
                  if (tally_count > res_cnt_ff) begin
                     res_cnt_in  = tally_count;
                     best_val_in = key_data;
                  end
                  if (outer_ff == last_idx) begin
                     state_in = ST_FINISH;
                  end else begin
                     outer_in = outer_ff + IDX_W'(1);
                     state_in = ST_KEY;
                  end
               end else begin
                  res_cnt_in = tally_count;
                  state_in   = ST_FINISH;
               end
            end
         end

         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in        = 1'b1;
               rsp_in.occurrences  = vsmf_pkg::CNT_W'(res_cnt_ff);
               rsp_in.mode_value   = $signed(best_wide[vsmf_pkg::DATA_W-1:0]);
               rsp_in.empty_error  = empty_ff;
               rsp_in.full_drop    = full_ff;
               rsp_in.entries      = vsmf_pkg::CNT_W'(fill_ff);
               state_in            = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      key_ff      <= key_in;
      outer_ff    <= outer_in;
      res_cnt_ff  <= res_cnt_in;
      best_val_ff <= best_val_in;
      empty_ff    <= empty_in;
      full_ff     <= full_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   vsmf_store #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_store (
      .clock     (clock),
      .wr_en     (mem_we),
      .wr_addr   (fill_ff[IDX_W-1:0]),
      .wr_data   (value_in),
      .rd_a_addr (outer_ff),
      .rd_a_data (key_data),
      .rd_b_addr (scan_addr),
      .rd_b_data (scan_data)
   );

   vsmf_tally #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_tally (
      .clock    (clock),
      .reset    (reset),
      .start    (tally_start),
      .last_idx (last_idx),
      .key      (tally_key),
      .rd_data  (scan_data),
      .rd_addr  (scan_addr),
      .count    (tally_count),
      .done     (tally_done)
   );

   // The fill count never passes the capacity.
   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FCNT_W'(CAPACITY))
      else $error("fill count above capacity");

   // The fill count moves only after an accepted add.
   assert property (@(posedge clock) disable iff (reset)
      ($past(!reset) && !$stable(fill_ff)) |->
         $past(req_accept && (req_payload.command == vsmf_pkg::CMD_ADD)))
      else $error("fill count changed without an add");

   // A finished scan is reported only while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      tally_done |-> (state_ff == ST_SCAN))
      else $error("tally finished outside of a scan");

   // The outer mode index stays within the stored entries.
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) || (state_ff == ST_KEY)) |-> (outer_ff <= last_idx))
      else $error("mode index beyond the stored entries");

endmodule
`default_nettype wire

>>> sim/value_store_mode_finder_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Value store mode finder testbench
// Drives add, count, mode and unused commands into the block through a
// valid/stall channel and compares every result against a cycle-free
// predictor of the store. It runs a directed opening, then random traffic
// under several idling patterns on both channels.
// ----------------------------------------------------------------------------
module value_store_mode_finder_tb;

   // The unused command code does nothing but report the fill level.
   localparam logic [vsmf_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

   localparam logic [vsmf_pkg::DATA_W-1:0] VALUE_MIN = 32'h8000_0000;
   localparam logic [vsmf_pkg::DATA_W-1:0] VALUE_MAX = 32'h7FFF_FFFF;
   localparam logic [vsmf_pkg::DATA_W-1:0] VALUE_NEG_ONE = 32'hFFFF_FFFF;

   localparam int RANDOM_ITEMS = 428;
   localparam int PHASE_ITEMS = 107;
   // A mode costs more the more entries the store holds, and the store
   // never shrinks, so the total spent on mode scans is capped. The cost
   // estimate below errs on the high side.
   localparam int MODE_BUDGET = 250_000;
   localparam int SETTLE_CYCLES = 200;
   localparam int LIMIT_CYCLES = 2_000_000;

   // -------------------------------------------------------------------------
   // Scoreboard: it mirrors the store, predicts the result of every accepted
   // command and keeps the predictions in order until the block answers.
   // -------------------------------------------------------------------------
   class mode_result_board;
      logic [vsmf_pkg::DATA_W-1:0] stored_values [vsmf_pkg::CAPACITY_DEF];
      int unsigned stored_count;
      vsmf_pkg::rsp_type expected_results [$];
      int unsigned mismatches;

      function new();
         stored_count = 0;
         mismatches = 0;
      endfunction

      // Number of stored entries equal to the key.
      function int unsigned tally(logic [vsmf_pkg::DATA_W-1:0] key);
         int unsigned hits;
         hits = 0;
         for (int i = 0; i < stored_count; i++) begin
            if (stored_values[i] == key) hits++;
         end
         return hits;
      endfunction

      // Applies one command to the mirrored store and returns its result.
      function vsmf_pkg::rsp_type predict_result(vsmf_pkg::req_type cmd);
         vsmf_pkg::rsp_type outcome;
         int unsigned best_hits;
         int unsigned hits;
         outcome = '0;
         case (cmd.command)
            vsmf_pkg::CMD_ADD: begin
               if (stored_count >= vsmf_pkg::CAPACITY_DEF) begin
                  outcome.full_drop = 1'b1;
               end else begin
                  stored_values[stored_count] = cmd.value;
                  stored_count++;
               end
            end
            vsmf_pkg::CMD_COUNT: begin
               outcome.occurrences = vsmf_pkg::CNT_W'(tally(cmd.value));
            end
            vsmf_pkg::CMD_MODE: begin
               if (stored_count == 0) begin
                  outcome.empty_error = 1'b1;
               end else begin
                  // Only a strictly larger count displaces the current
                  // best, so ties stay with the earliest stored value.
                  outcome.mode_value = stored_values[0];
                  best_hits = tally(stored_values[0]);
                  for (int i = 1; i < stored_count; i++) begin
                     hits = tally(stored_values[i]);
                     if (hits > best_hits) begin
                        best_hits = hits;
                        outcome.mode_value = stored_values[i];
                     end
                  end
                  outcome.occurrences = vsmf_pkg::CNT_W'(best_hits);
               end
            end
            default: begin
            end
         endcase
         outcome.entries = vsmf_pkg::CNT_W'(stored_count);
         return outcome;
      endfunction

      function void note_command(vsmf_pkg::req_type cmd);
         expected_results.push_back(predict_result(cmd));
      endfunction

      task report_mismatch(string what);
         $display("ERROR: %s", what);
         mismatches++;
      endtask

      task check_result(vsmf_pkg::rsp_type got);
         vsmf_pkg::rsp_type want;
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("result with nothing pending: %p", got));
            return;
         end
         want = expected_results.pop_front();
         if (got.occurrences !== want.occurrences)
            report_mismatch($sformatf("occurrences %0d, predicted %0d",
                                      got.occurrences, want.occurrences));
         if (got.mode_value !== want.mode_value)
            report_mismatch($sformatf("mode_value %h, predicted %h",
                                      got.mode_value, want.mode_value));
         if (got.empty_error !== want.empty_error)
            report_mismatch($sformatf("empty_error %b, predicted %b",
                                      got.empty_error, want.empty_error));
         if (got.full_drop !== want.full_drop)
            report_mismatch($sformatf("full_drop %b, predicted %b",
                                      got.full_drop, want.full_drop));
         if (got.entries !== want.entries)
            report_mismatch($sformatf("entries %0d, predicted %0d",
                                      got.entries, want.entries));
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Block under test and its signals. Every input starts at a known value.
   // -------------------------------------------------------------------------
   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   vsmf_pkg::req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   vsmf_pkg::rsp_type rsp_payload;

   value_store_mode_finder u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   mode_result_board results_board = new();

   // Idling pattern: 0 none, 1 sender idle, 2 receiver stalls, 3 both.
   int idle_phase = 0;
   int unsigned mode_scan_cycles = 0;
   int unsigned cycle_count = 0;
   logic [vsmf_pkg::DATA_W-1:0] value_pool [8];

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // The run is stopped here if the block hangs or loses a transaction.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Both channels are observed at the rising edge only. The testbench
   // drives at the falling edge, so the values seen here are settled.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) results_board.note_command(req_payload);
         if (rsp_valid && !rsp_stall) results_board.check_result(rsp_payload);
      end
   end

   function automatic int sender_idle_percent();
      case (idle_phase)
         1: return 71;
         3: return 25;
         default: return 0;
      endcase
   endfunction

   function automatic int receiver_stall_percent();
      case (idle_phase)
         2: return 71;
         3: return 25;
         default: return 0;
      endcase
   endfunction

   // The receiver decides its stall once per cycle, at the falling edge.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99, 0) < receiver_stall_percent());
   end

   // Presents one transaction and holds it until the block accepts it.
   // It returns at the falling edge after the accepting rising edge.
   task automatic send_item(vsmf_pkg::req_type item);
      while ($urandom_range(99, 0) < sender_idle_percent()) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_payload <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Stops sending and waits until every pending result has arrived.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (results_board.expected_results.size() != 0) @(negedge clock);
   endtask

   // Most values come from a small pool so that counts and modes see
   // repeats and ties; the rest are spread over the whole range.
   function automatic logic [vsmf_pkg::DATA_W-1:0] random_value();
      if ($urandom_range(99, 0) < 60) return value_pool[$urandom_range(7, 0)];
      return $urandom;
   endfunction

   // Count keys favor values that are actually stored.
   function automatic logic [vsmf_pkg::DATA_W-1:0] count_key();
      int unsigned roll;
      int unsigned fill;
      roll = $urandom_range(99, 0);
      fill = results_board.stored_count;
      if (roll < 50 && fill > 0) return results_board.stored_values[$urandom_range(fill - 1, 0)];
      if (roll < 75) return value_pool[$urandom_range(7, 0)];
      return $urandom;
   endfunction

   // About a quarter of the commands are adds, so the store fills around
   // the middle of the random part and later adds exercise the full drop.
   // Modes turn into counts once the scan budget is spent.
   function automatic vsmf_pkg::req_type next_random_command();
      vsmf_pkg::req_type item;
      int unsigned roll;
      int unsigned fill;
      int unsigned cost;
      roll = $urandom_range(99, 0);
      fill = results_board.stored_count;
      item.value = random_value();
      if (roll < 25) begin
         item.command = vsmf_pkg::CMD_ADD;
      end else if (roll < 70) begin
         item.command = vsmf_pkg::CMD_COUNT;
         item.value = count_key();
      end else if (roll < 95) begin
         cost = (fill + 1) * (fill + 4) + 4;
         if (mode_scan_cycles + cost <= MODE_BUDGET) begin
            item.command = vsmf_pkg::CMD_MODE;
            mode_scan_cycles += cost;
         end else begin
            item.command = vsmf_pkg::CMD_COUNT;
            item.value = count_key();
         end
      end else begin
         item.command = CMD_UNUSED;
      end
      return item;
   endfunction

   initial begin
      value_pool[0] = VALUE_MIN;
      value_pool[1] = VALUE_MAX;
      value_pool[2] = '0;
      value_pool[3] = VALUE_NEG_ONE;
      value_pool[4] = 32'd1;
      value_pool[5] = $urandom;
      value_pool[6] = $urandom;
      value_pool[7] = $urandom;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed opening. The empty store comes first: a mode reports the
      // empty error, a count finds nothing and the unused code is a no-op.
      send_item('{vsmf_pkg::CMD_MODE, VALUE_MAX});
      send_item('{vsmf_pkg::CMD_COUNT, 32'd0});
      send_item('{CMD_UNUSED, 32'd0});
      // Extremes of the value range, then ties that must go to the
      // earliest stored value and a clear winner in between.
      send_item('{vsmf_pkg::CMD_ADD, VALUE_MIN});
      send_item('{vsmf_pkg::CMD_ADD, VALUE_MAX});
      send_item('{vsmf_pkg::CMD_MODE, 32'd0});
      send_item('{vsmf_pkg::CMD_ADD, VALUE_MAX});
      send_item('{vsmf_pkg::CMD_MODE, 32'd0});
      send_item('{vsmf_pkg::CMD_ADD, VALUE_MIN});
      send_item('{vsmf_pkg::CMD_MODE, 32'd0});
      send_item('{vsmf_pkg::CMD_ADD, 32'd0});
      send_item('{vsmf_pkg::CMD_ADD, VALUE_NEG_ONE});
      send_item('{vsmf_pkg::CMD_ADD, VALUE_NEG_ONE});
      send_item('{vsmf_pkg::CMD_ADD, VALUE_NEG_ONE});
      send_item('{vsmf_pkg::CMD_MODE, 32'd0});
      send_item('{vsmf_pkg::CMD_COUNT, VALUE_MIN});
      send_item('{vsmf_pkg::CMD_COUNT, VALUE_MAX});
      send_item('{vsmf_pkg::CMD_COUNT, 32'd0});
      send_item('{vsmf_pkg::CMD_COUNT, 32'd5});
      // The unused code and the mode both ignore a nonzero value.
      send_item('{CMD_UNUSED, VALUE_NEG_ONE});
      send_item('{vsmf_pkg::CMD_MODE, VALUE_MAX});
      send_item('{vsmf_pkg::CMD_COUNT, VALUE_NEG_ONE});
      drain_results();

      // Random traffic in four idling patterns. The sender drains the
      // block completely before each change of pattern.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n != 0 && n % PHASE_ITEMS == 0) begin
            drain_results();
            idle_phase = n / PHASE_ITEMS;
         end
         send_item(next_random_command());
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (results_board.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
`default_nettype wire

>>> sim.f
hw/rtl/vsmf_pkg.sv
hw/rtl/vsmf_store.sv
hw/rtl/vsmf_tally.sv
hw/rtl/value_store_mode_finder.sv
sim/value_store_mode_finder_tb.sv
